### sv/ttps_pkg.sv
// ttps_pkg: shared types, constants and helper functions of the transposition table
// probe and store unit. Used by the interfaces, the controller, the datapath and
// the top level. No dependencies.
package ttps_pkg;

  localparam int TABLE_ENTRIES_DEF = 4096;

  localparam int KEY_W   = 64;
  localparam int DEPTH_W = 8;
  localparam int KIND_W  = 2;
  localparam int SCORE_W = 16;
  localparam int SQ_W    = 6;
  localparam int MOVE_W  = 7;

  // request codes
  localparam logic REQ_STORE = 1'b0;
  localparam logic REQ_PROBE = 1'b1;

  // bound kinds
  localparam logic [KIND_W-1:0] KIND_EXACT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOWER = 2'd1;
  localparam logic [KIND_W-1:0] KIND_UPPER = 2'd2;

  localparam logic signed [SCORE_W-1:0] SCORE_MIN = 16'sh8000;
  localparam logic signed [SCORE_W-1:0] SCORE_MAX = 16'sh7fff;

  localparam logic [MOVE_W-1:0] MISS_SQUARE = 7'd64;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_EVAL
  } state_t;

  typedef struct packed {
    logic                      req_type;
    logic [KEY_W-1:0]          pos_key;
    logic [DEPTH_W-1:0]        search_depth;
    logic [KIND_W-1:0]         bound_kind;
    logic signed [SCORE_W-1:0] score_in;
    logic [SQ_W-1:0]           from_square;
    logic [SQ_W-1:0]           to_square;
    logic signed [SCORE_W-1:0] alpha_bound;
    logic signed [SCORE_W-1:0] beta_bound;
    logic                      side_black;
  } req_t;

  typedef struct packed {
    logic                      hit;
    logic signed [SCORE_W-1:0] score_out;
    logic [MOVE_W-1:0]         move_from;
    logic [MOVE_W-1:0]         move_to;
  } rsp_t;

  // one table entry besides its key, 39 bits
  typedef struct packed {
    logic                      black;
    logic [SQ_W-1:0]           to_sq;
    logic [SQ_W-1:0]           from_sq;
    logic signed [SCORE_W-1:0] score;
    logic [KIND_W-1:0]         kind;
    logic [DEPTH_W-1:0]        depth;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic clr_step;
    logic write;
    logic read;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic idx_done;
    logic is_probe;
    logic out_free;
  } stat_t;

  // lower and upper swap, anything else becomes exact
  function automatic logic [KIND_W-1:0] flip_kind(input logic [KIND_W-1:0] k);
    logic [KIND_W-1:0] r;
    if (k == KIND_LOWER) begin
      r = KIND_UPPER;
    end else if (k == KIND_UPPER) begin
      r = KIND_LOWER;
    end else begin
      r = KIND_EXACT;
    end
    return r;
  endfunction

  // negation that saturates the most negative score
  function automatic logic signed [SCORE_W-1:0] neg_sat(input logic signed [SCORE_W-1:0] s);
    logic signed [SCORE_W-1:0] r;
    r = (s == SCORE_MIN) ? SCORE_MAX : -s;
    return r;
  endfunction

endpackage

### sv/ttps_if.sv
// ttps_req_if and ttps_rsp_if: valid/ready channels of the probe and store unit.
// Depends on ttps_pkg for field widths.
interface ttps_req_if;
  logic                                        valid;
  logic                                        ready;
  logic                                        req_type;
  logic [ttps_pkg::KEY_W-1:0]                  pos_key;
  logic [ttps_pkg::DEPTH_W-1:0]                search_depth;
  logic [ttps_pkg::KIND_W-1:0]                 bound_kind;
  logic signed [ttps_pkg::SCORE_W-1:0]         score_in;
  logic [ttps_pkg::SQ_W-1:0]                   from_square;
  logic [ttps_pkg::SQ_W-1:0]                   to_square;
  logic signed [ttps_pkg::SCORE_W-1:0]         alpha_bound;
  logic signed [ttps_pkg::SCORE_W-1:0]         beta_bound;
  logic                                        side_black;

  modport source (
    output valid, req_type, pos_key, search_depth, bound_kind, score_in,
           from_square, to_square, alpha_bound, beta_bound, side_black,
    input  ready
  );
  modport sink (
    input  valid, req_type, pos_key, search_depth, bound_kind, score_in,
           from_square, to_square, alpha_bound, beta_bound, side_black,
    output ready
  );
endinterface

interface ttps_rsp_if;
  logic                                valid;
  logic                                ready;
  logic                                hit;
  logic signed [ttps_pkg::SCORE_W-1:0] score_out;
  logic [ttps_pkg::MOVE_W-1:0]         move_from;
  logic [ttps_pkg::MOVE_W-1:0]         move_to;

  modport source (
    output valid, hit, score_out, move_from, move_to,
    input  ready
  );
  modport sink (
    input  valid, hit, score_out, move_from, move_to,
    output ready
  );
endinterface

### sv/transposition_table_probe_store_unit.sv
// transposition_table_probe_store_unit: top level of the direct-mapped search table.
// Depends on ttps_pkg, ttps_if, ttps_ctrl, ttps_dp and ttps_index.
//
// Direct-mapped transposition table. Each request on req either stores an entry
// (req_type 0, no response) or probes the table (req_type 1, one response on rsp).
// The entry is chosen by pos_key modulo TABLE_ENTRIES. For black, bound kinds
// lower and upper swap and the score is negated (saturating) on both store and
// probe. A probe hits when the entry is valid, key and side match, the stored depth
// is at least search_depth and the bound test against alpha and beta passes; a miss
// answers score 0 and squares 64. After reset the block runs a clearing pass over
// the valid bits, one entry a cycle, with req_ready low. A store passes through
// request and memory access, a probe through request, memory access and
// evaluation; a table size that is not a power of two adds the key remainder
// (byte fold, reciprocal multiply, subtract) to every request. Probe results
// sit in an output register, so a new request is taken while a response still
// waits on rsp.
module transposition_table_probe_store_unit #(
  parameter int TABLE_ENTRIES = ttps_pkg::TABLE_ENTRIES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  ttps_req_if.sink  req,
  ttps_rsp_if.source rsp
);

  ttps_pkg::cmd_t  cmd;
  ttps_pkg::stat_t stat;
  ttps_pkg::req_t  req_in;
  ttps_pkg::rsp_t  rsp_out;

  // gather request fields into one word
  always_comb begin
    req_in.req_type     = req.req_type;
    req_in.pos_key      = req.pos_key;
    req_in.search_depth = req.search_depth;
    req_in.bound_kind   = req.bound_kind;
    req_in.score_in     = req.score_in;
    req_in.from_square  = req.from_square;
    req_in.to_square    = req.to_square;
    req_in.alpha_bound  = req.alpha_bound;
    req_in.beta_bound   = req.beta_bound;
    req_in.side_black   = req.side_black;
  end

  // sequencing: clear pass, request intake, memory access, probe evaluation
  ttps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req.valid),
    .req_ready(req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // memories, index unit and response register
  ttps_dp #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .req_in   (req_in),
    .rsp_out  (rsp_out),
    .rsp_valid(rsp.valid),
    .rsp_ready(rsp.ready)
  );

  // response fields out to the channel
  assign rsp.hit       = rsp_out.hit;
  assign rsp.score_out = rsp_out.score_out;
  assign rsp.move_from = rsp_out.move_from;
  assign rsp.move_to   = rsp_out.move_to;

endmodule

### sv/ttps_index.sv
// ttps_index: table index from the position key, key modulo the table size.
// A mask for power-of-two sizes, otherwise a byte fold, a reciprocal multiply
// and a subtract. Depends on ttps_pkg.
module ttps_index #(
  parameter int TABLE_ENTRIES = ttps_pkg::TABLE_ENTRIES_DEF,
  parameter int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [ttps_pkg::KEY_W-1:0] key,
  output logic [IDX_W-1:0]           idx,
  output logic                       done
);

  localparam bit IS_POW2 = ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0);

  // 2^(8*pos) modulo the table size, elaboration only
  function automatic logic [IDX_W-1:0] byte_weight(input int pos);
    longint w;
    w = 1;
    for (int i = 0; i < pos; i++) begin
      w = (w * 256) % TABLE_ENTRIES;
    end
    return IDX_W'(w);
  endfunction

  if (IS_POW2) begin : g_mask
    localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(TABLE_ENTRIES - 1);
    logic [IDX_W-1:0] idx_r;

    always_ff @(posedge clk) begin
      if (rst) begin
        idx_r <= '0;
      end else if (start) begin
        idx_r <= key[IDX_W-1:0] & IDX_MASK;
      end
    end

    assign idx  = idx_r;
    assign done = 1'b1;
  end else begin : g_fold
    localparam int KEY_BYTES = 8;
    // folded value stays below 2^11 times the table size
    localparam int Y_W  = IDX_W + 11;
    localparam int Q_W  = 11;
    localparam int S_SH = Y_W + IDX_W;
    localparam int M_W  = Y_W + 2;
    localparam int P_W  = Y_W + M_W;
    localparam logic [M_W-1:0] RECIP =
      M_W'(((64'd1 << S_SH) + 64'(TABLE_ENTRIES) - 64'd1) / 64'(TABLE_ENTRIES));
    localparam logic [Y_W-1:0] NVAL = Y_W'(TABLE_ENTRIES);
    localparam logic [KEY_BYTES-1:0][IDX_W-1:0] WEIGHTS = {
      byte_weight(7), byte_weight(6), byte_weight(5), byte_weight(4),
      byte_weight(3), byte_weight(2), byte_weight(1), byte_weight(0)
    };

    logic [Y_W-1:0]   fold;
    logic [Y_W-1:0]   fold_r;
    logic [Q_W-1:0]   quot_r;
    logic [IDX_W-1:0] rem_r;
    logic [P_W-1:0]   prod;
    logic [Y_W-1:0]   qn;
    logic             fold_ok;
    logic             quot_ok;

    // each key byte weighted by its place value modulo the table size
    always_comb begin
      fold = '0;
      for (int b = 0; b < KEY_BYTES; b++) begin
        fold = fold + Y_W'(key[8*b +: 8]) * Y_W'(WEIGHTS[b]);
      end
    end

    assign prod = P_W'(fold_r) * P_W'(RECIP);
    assign qn   = Y_W'(quot_r) * NVAL;

    always_ff @(posedge clk) begin
      if (rst) begin
        fold_ok <= 1'b0;
        quot_ok <= 1'b0;
      end else begin
        fold_ok <= start;
        quot_ok <= fold_ok;
      end
    end

    always_ff @(posedge clk) begin
      if (start) begin
        fold_r <= fold;
      end
      if (fold_ok) begin
        quot_r <= prod[S_SH +: Q_W];
      end
      if (quot_ok) begin
        rem_r <= IDX_W'(fold_r - qn);
      end
    end

    assign idx  = rem_r;
    assign done = !fold_ok && !quot_ok;
  end

endmodule

### sv/ttps_dp.sv
// ttps_dp: datapath of the probe and store unit: request register, key, data and
// valid memories, clearing counter, hit evaluation and result register.
// Depends on ttps_pkg and ttps_index.
module ttps_dp #(
  parameter int TABLE_ENTRIES = ttps_pkg::TABLE_ENTRIES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  ttps_pkg::cmd_t cmd,
  output ttps_pkg::stat_t stat,
  input  ttps_pkg::req_t req_in,
  output ttps_pkg::rsp_t rsp_out,
  output logic           rsp_valid,
  input  logic           rsp_ready
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  ttps_pkg::req_t   cur;
  logic [IDX_W-1:0] idx;
  logic             idx_done;
  logic [IDX_W-1:0] clr_cnt;

  logic [ttps_pkg::KEY_W-1:0] key_mem [TABLE_ENTRIES];
  ttps_pkg::entry_t           data_mem [TABLE_ENTRIES];
  logic                       valid_mem [TABLE_ENTRIES];

  logic [ttps_pkg::KEY_W-1:0] rd_key;
  ttps_pkg::entry_t           rd_data;
  logic                       rd_valid;

  ttps_pkg::entry_t                    w_entry;
  logic [ttps_pkg::KIND_W-1:0]         e_kind;
  logic signed [ttps_pkg::SCORE_W-1:0] e_score;
  logic                                match;
  logic                                bound_ok;
  ttps_pkg::rsp_t                      rsp_next;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur <= req_in;
    end
  end

  ttps_index #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .IDX_W        (IDX_W)
  ) u_index (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.accept),
    .key  (req_in.pos_key),
    .idx  (idx),
    .done (idx_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // entry as written, colour flip applied for black
  always_comb begin
    w_entry.depth   = cur.search_depth;
    w_entry.kind    = cur.side_black ? ttps_pkg::flip_kind(cur.bound_kind) : cur.bound_kind;
    w_entry.score   = cur.side_black ? ttps_pkg::neg_sat(cur.score_in) : cur.score_in;
    w_entry.from_sq = cur.from_square;
    w_entry.to_sq   = cur.to_square;
    w_entry.black   = cur.side_black;
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      key_mem[idx] <= cur.pos_key;
    end
    if (cmd.read) begin
      rd_key <= key_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      data_mem[idx] <= w_entry;
    end
    if (cmd.read) begin
      rd_data <= data_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      valid_mem[clr_cnt] <= 1'b0;
    end else if (cmd.write) begin
      valid_mem[idx] <= 1'b1;
    end
    if (cmd.read) begin
      rd_valid <= valid_mem[idx];
    end
  end

  // probe evaluation on the registered read data
  always_comb begin
    e_kind  = cur.side_black ? ttps_pkg::flip_kind(rd_data.kind) : rd_data.kind;
    e_score = cur.side_black ? ttps_pkg::neg_sat(rd_data.score) : rd_data.score;
    match   = rd_valid && (rd_data.black == cur.side_black) && (rd_key == cur.pos_key)
              && (rd_data.depth >= cur.search_depth);
    bound_ok = (e_kind == ttps_pkg::KIND_EXACT)
               || ((e_kind == ttps_pkg::KIND_LOWER) && (e_score >= cur.beta_bound))
               || ((e_kind == ttps_pkg::KIND_UPPER) && (e_score <= cur.alpha_bound));
    if (match && bound_ok) begin
      rsp_next.hit       = 1'b1;
      rsp_next.score_out = e_score;
      rsp_next.move_from = {1'b0, rd_data.from_sq};
      rsp_next.move_to   = {1'b0, rd_data.to_sq};
    end else begin
      rsp_next.hit       = 1'b0;
      rsp_next.score_out = '0;
      rsp_next.move_from = ttps_pkg::MISS_SQUARE;
      rsp_next.move_to   = ttps_pkg::MISS_SQUARE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp_out <= rsp_next;
    end
  end

  always_comb begin
    stat.clr_last = (clr_cnt == LAST_IDX);
    stat.idx_done = idx_done;
    stat.is_probe = (cur.req_type == ttps_pkg::REQ_PROBE);
    stat.out_free = !rsp_valid || rsp_ready;
  end

endmodule

### sv/ttps_ctrl.sv
// ttps_ctrl: controller state machine of the probe and store unit.
// Depends on ttps_pkg.
module ttps_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  ttps_pkg::stat_t stat,
  output ttps_pkg::cmd_t  cmd
);

  ttps_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ttps_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    cmd        = '0;
    unique case (state)
      ttps_pkg::ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_next = ttps_pkg::ST_IDLE;
        end
      end
      ttps_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = ttps_pkg::ST_ACCESS;
        end
      end
      ttps_pkg::ST_ACCESS: begin
        if (stat.idx_done) begin
          if (stat.is_probe) begin
            cmd.read   = 1'b1;
            state_next = ttps_pkg::ST_EVAL;
          end else begin
            cmd.write  = 1'b1;
            state_next = ttps_pkg::ST_IDLE;
          end
        end
      end
      ttps_pkg::ST_EVAL: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ttps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ttps_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
